// ----- rtl/insertable_array_store_macros.svh -----
// Assertion macros shared by the insertable array store RTL.
`ifndef INSERTABLE_ARRAY_STORE_MACROS_SVH
`define INSERTABLE_ARRAY_STORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define IAS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("insertable_array_store: assertion failed");
// Check that a condition implies another in the same cycle.
`define IAS_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("insertable_array_store: implication failed");
// Check that a condition implies another in the next cycle.
`define IAS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("insertable_array_store: next-cycle check failed");
`else
`define IAS_ASSERT(label, clk, rst, prop)
`define IAS_ASSERT_IMPLY(label, clk, rst, pre, post)
`define IAS_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ----- rtl/ias_pkg.sv -----
// Types and constants of the insertable array store.
package ias_pkg;

   localparam int WORD_W  = 64;
   localparam int FIELD_W = 7;

   // Request opcodes
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_SET    = 3'd3,
      OP_GET    = 3'd4,
      OP_RESIZE = 3'd5
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Action broadcast to every cell
   typedef enum logic [2:0] {
      ACT_HOLD   = 3'd0,
      ACT_WRITE  = 3'd1,
      ACT_INSERT = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_FILL   = 3'd4
   } act_type;

   typedef struct packed {
      op_type              opcode;
      logic [FIELD_W-1:0]  index;
      logic [FIELD_W-1:0]  new_length;
      logic [WORD_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   read_value;
      logic [FIELD_W-1:0]  length;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      act_type             act;
      logic [WORD_W-1:0]   value;
   } cmd_type;

endpackage

// ----- rtl/ias_cell.sv -----
// One storage cell of the array: holds a word and trades it with its neighbors.
module ias_cell
   import ias_pkg::*;
#(
   parameter int POS = 0,
   parameter int PW  = 7
) (
   input  logic              clock,
   input  cmd_type           cmd,
   input  logic [PW-1:0]     pos_lo,
   input  logic [PW-1:0]     pos_hi,
   input  logic [WORD_W-1:0] left_data,
   input  logic [WORD_W-1:0] right_data,
   output logic [WORD_W-1:0] data
);

   localparam logic [PW-1:0] HERE = PW'(POS);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   // Pick the next word from self, neighbor, request value or zero
   always_comb begin
      data_in = data_ff;
      unique case (cmd.act)
         ACT_HOLD: begin
            data_in = data_ff;
         end
         ACT_WRITE: begin
            if (HERE == pos_lo) data_in = cmd.value;
         end
         ACT_INSERT: begin
            if (HERE > pos_lo) data_in = left_data;
            else if (HERE == pos_lo) data_in = cmd.value;
         end
         ACT_DELETE: begin
            if (HERE >= pos_lo) data_in = right_data;
         end
         ACT_FILL: begin
            if (HERE >= pos_lo && HERE < pos_hi) data_in = '0;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/insertable_array_store.sv -----
// Top level of the insertable array store: request decode, cell chain, result register.
//
// An ordered array of up to CAPACITY 64-bit words with a current length.
// A request (opcode, index, new_length, value on req_item) is taken at a
// rising edge where start is high and busy is low. Opcodes: push, insert,
// delete, set, get and resize; out-of-range or full requests change nothing
// and report a status code.
// Every element sits in its own cell; cells pass words to their neighbors,
// so an insert or delete shifts the cells from the index upward in the clock
// edge that takes the request.
// Latency: the result appears on rsp_item with rsp_strobe high in the cycle
// after the request is taken, for exactly one cycle. Throughput: one
// request per cycle while busy is low; the cell chain updates in the clock
// edge that takes the request; a get reads through one AND-OR selection
// across the cells. Reset holds busy high while asserted and until the first
// edge after release, clears the length to zero and drops any pending result.
// Cell contents are not cleared; only entries below the length are ever read.
// The receiver takes each result as it is shown and cannot stall the block.
module insertable_array_store
   import ias_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

`include "insertable_array_store_macros.svh"

   localparam int CW = ($clog2(CAPACITY + 1) > FIELD_W) ? $clog2(CAPACITY + 1) : FIELD_W;
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic              busy_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              strobe_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              accept;
   logic [CW-1:0]     idx_ext;
   logic [CW-1:0]     len_ext;
   logic              get_ok;
   logic [WORD_W-1:0] read_word;
   cmd_type           cmd;
   logic [CW-1:0]     pos_lo;
   logic [CW-1:0]     pos_hi;
   status_type        status;
   logic [WORD_W-1:0] cell_data [CAPACITY];

   assign accept  = start && !busy_ff;
   assign idx_ext = CW'(req_item.index);
   assign len_ext = CW'(req_item.new_length);

   // Decode the request into a cell action and the next length
   always_comb begin
      cmd.act   = ACT_HOLD;
      cmd.value = req_item.value;
      pos_lo    = idx_ext;
      pos_hi    = len_ext;
      count_in  = count_ff;
      status    = ST_OK;
      get_ok    = 1'b0;
      unique case (req_item.opcode)
         OP_PUSH: begin
            if (count_ff >= CAP) begin
               status = ST_FULL;
            end else begin
               cmd.act  = ACT_WRITE;
               pos_lo   = count_ff;
               count_in = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (idx_ext > count_ff) begin
               status = ST_RANGE;
            end else if (count_ff >= CAP) begin
               status = ST_FULL;
            end else begin
               cmd.act  = ACT_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (idx_ext >= count_ff) begin
               status = ST_RANGE;
            end else begin
               cmd.act  = ACT_DELETE;
               count_in = count_ff - 1'b1;
            end
         end
         OP_SET: begin
            if (idx_ext >= count_ff) status = ST_RANGE;
            else cmd.act = ACT_WRITE;
         end
         OP_GET: begin
            if (idx_ext >= count_ff) status = ST_RANGE;
            else get_ok = 1'b1;
         end
         OP_RESIZE: begin
            if (len_ext > CAP) begin
               status = ST_RANGE;
            end else begin
               cmd.act  = ACT_FILL;
               pos_lo   = count_ff;
               count_in = len_ext;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      // Drop everything unless the request is taken
      if (!accept) begin
         cmd.act  = ACT_HOLD;
         count_in = count_ff;
      end
   end

   // Cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;
      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_word = cell_data[g];
      end else begin : g_right
         assign right_word = cell_data[g+1];
      end
      ias_cell #(
         .POS (g),
         .PW  (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos_lo     (pos_lo),
         .pos_hi     (pos_hi),
         .left_data  (left_word),
         .right_data (right_word),
         .data       (cell_data[g])
      );
   end

   // Select the addressed cell for a get
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (get_ok && idx_ext == CW'(i)) read_word = read_word | cell_data[i];
      end
   end

   always_comb begin
      rsp_in.read_value = read_word;
      rsp_in.length     = count_in[FIELD_W-1:0];
      rsp_in.status     = status;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `IAS_ASSERT(a_count_bound, clock, reset, count_ff <= CAP)
   `IAS_ASSERT_NEXT(a_accept_strobe, clock, reset, accept, strobe_ff)
   `IAS_ASSERT_IMPLY(a_strobe_cause, clock, reset, strobe_ff, $past(accept))
   `IAS_ASSERT_IMPLY(a_full_status, clock, reset, accept && status == ST_FULL, count_ff == CAP)
   `IAS_ASSERT_IMPLY(a_reject_hold, clock, reset, accept && status != ST_OK, count_in == count_ff)

endmodule
